### hdl/cmfs_pkg.sv
// Shared types and constants for the cube-map face select pipeline.
package cmfs_pkg;

    // Coordinate format: unsigned Q1.15, 1.0 = 32768
    localparam int COORD_BITS = 16;
    localparam logic [COORD_BITS-1:0] HALF_Q15 = 16'd16384;

    // Quotient magnitude |q| = |num|*2^14/|major| lies in 0..16384
    localparam int QBITS = 15;

    // Divider split: quotient bits resolved per pipeline stage
    localparam int DIV_STEPS_PER_STAGE = 3;
    localparam int DIV_STAGES          = QBITS / DIV_STEPS_PER_STAGE;

    typedef enum logic [2:0] {
        FACE_POS_X = 3'd0,
        FACE_NEG_X = 3'd1,
        FACE_POS_Y = 3'd2,
        FACE_NEG_Y = 3'd3,
        FACE_POS_Z = 3'd4,
        FACE_NEG_Z = 3'd5
    } face_t;

    // Per-item control that rides alongside the divider data
    typedef struct packed {
        face_t face;
        logic  neg_u;
        logic  neg_v;
        logic  degenerate;
    } cmfs_tag_t;

endpackage

### hdl/cmfs_select.sv
// Front stage: component magnitudes, major-axis pick and per-face numerators.
module cmfs_select #(
    parameter int N = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [N-1:0]   dir_x,
    input  logic signed [N-1:0]   dir_y,
    input  logic signed [N-1:0]   dir_z,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [N-1:0]          major,
    output logic [N:0]            rem_u,
    output logic [N:0]            rem_v,
    output cmfs_pkg::cmfs_tag_t   tag
);
    import cmfs_pkg::*;

    logic          valid_reg;
    logic [N-1:0]  major_reg, major_next;
    logic [N:0]    rem_u_reg, rem_v_reg;
    logic [N-1:0]  num_u_next, num_v_next;
    cmfs_tag_t     tag_reg, tag_next;

    logic [N-1:0]  ax, ay, az;
    logic          x_neg, y_neg, z_neg;
    logic          x_pos, y_pos, z_pos;   // strictly greater than zero
    logic          load;

    assign x_neg = dir_x[N-1];
    assign y_neg = dir_y[N-1];
    assign z_neg = dir_z[N-1];
    assign x_pos = !dir_x[N-1] && (|dir_x);
    assign y_pos = !dir_y[N-1] && (|dir_y);
    assign z_pos = !dir_z[N-1] && (|dir_z);

    // Most negative value maps to 2^(N-1), still exact in N unsigned bits
    assign ax = x_neg ? (~dir_x + 1'b1) : dir_x;
    assign ay = y_neg ? (~dir_y + 1'b1) : dir_y;
    assign az = z_neg ? (~dir_z + 1'b1) : dir_z;

    always_comb begin
        tag_next = '0;
        if (ax >= ay && ax >= az) begin
            major_next = ax;
            num_u_next = az;
            num_v_next = ay;
            tag_next.neg_v = y_pos;
            if (!x_neg) begin
                tag_next.face  = FACE_POS_X;
                tag_next.neg_u = z_pos;
            end else begin
                tag_next.face  = FACE_NEG_X;
                tag_next.neg_u = z_neg;
            end
        end else if (ay >= az) begin
            major_next = ay;
            num_u_next = ax;
            num_v_next = az;
            tag_next.neg_u = x_neg;
            if (!y_neg) begin
                tag_next.face  = FACE_POS_Y;
                tag_next.neg_v = z_neg;
            end else begin
                tag_next.face  = FACE_NEG_Y;
                tag_next.neg_v = z_pos;
            end
        end else begin
            major_next = az;
            num_u_next = ax;
            num_v_next = ay;
            tag_next.neg_v = y_pos;
            if (!z_neg) begin
                tag_next.face  = FACE_POS_Z;
                tag_next.neg_u = x_neg;
            end else begin
                tag_next.face  = FACE_NEG_Z;
                tag_next.neg_u = x_pos;
            end
        end
        tag_next.degenerate = (major_next == '0);
    end

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            major_reg <= major_next;
            rem_u_reg <= {1'b0, num_u_next};
            rem_v_reg <= {1'b0, num_v_next};
            tag_reg   <= tag_next;
        end
    end

    assign out_valid = valid_reg;
    assign major     = major_reg;
    assign rem_u     = rem_u_reg;
    assign rem_v     = rem_v_reg;
    assign tag       = tag_reg;

endmodule

### hdl/cmfs_div_stage.sv
// One stage of the two-lane restoring divider: STEPS quotient bits per stage.
module cmfs_div_stage #(
    parameter int N           = 16,
    parameter int STEPS       = 3,
    parameter bit FIRST_STAGE = 1'b0
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [N-1:0]                in_major,
    input  logic [N:0]                  in_rem_u,
    input  logic [N:0]                  in_rem_v,
    input  logic [cmfs_pkg::QBITS-1:0]  in_q_u,
    input  logic [cmfs_pkg::QBITS-1:0]  in_q_v,
    input  cmfs_pkg::cmfs_tag_t         in_tag,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [N-1:0]                out_major,
    output logic [N:0]                  out_rem_u,
    output logic [N:0]                  out_rem_v,
    output logic [cmfs_pkg::QBITS-1:0]  out_q_u,
    output logic [cmfs_pkg::QBITS-1:0]  out_q_v,
    output cmfs_pkg::cmfs_tag_t         out_tag
);
    import cmfs_pkg::*;

    logic              valid_reg;
    logic [N-1:0]      major_reg;
    logic [N:0]        rem_u_reg, rem_u_next;
    logic [N:0]        rem_v_reg, rem_v_next;
    logic [QBITS-1:0]  q_u_reg, q_u_next;
    logic [QBITS-1:0]  q_v_reg, q_v_next;
    cmfs_tag_t         tag_reg;
    logic [N:0]        dvs;
    logic              load;

    assign dvs = {1'b0, in_major};

    // Remainder stays below the divisor after each step, so the shift never
    // drops a set bit. The very first step takes the numerator unshifted.
    always_comb begin
        rem_u_next = in_rem_u;
        rem_v_next = in_rem_v;
        q_u_next   = in_q_u;
        q_v_next   = in_q_v;
        for (int s = 0; s < STEPS; s++) begin
            if (!(FIRST_STAGE && s == 0)) begin
                rem_u_next = {rem_u_next[N-1:0], 1'b0};
                rem_v_next = {rem_v_next[N-1:0], 1'b0};
            end
            if (rem_u_next >= dvs) begin
                rem_u_next = rem_u_next - dvs;
                q_u_next   = {q_u_next[QBITS-2:0], 1'b1};
            end else begin
                q_u_next   = {q_u_next[QBITS-2:0], 1'b0};
            end
            if (rem_v_next >= dvs) begin
                rem_v_next = rem_v_next - dvs;
                q_v_next   = {q_v_next[QBITS-2:0], 1'b1};
            end else begin
                q_v_next   = {q_v_next[QBITS-2:0], 1'b0};
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            major_reg <= in_major;
            rem_u_reg <= rem_u_next;
            rem_v_reg <= rem_v_next;
            q_u_reg   <= q_u_next;
            q_v_reg   <= q_v_next;
            tag_reg   <= in_tag;
        end
    end

    assign out_valid = valid_reg;
    assign out_major = major_reg;
    assign out_rem_u = rem_u_reg;
    assign out_rem_v = rem_v_reg;
    assign out_q_u   = q_u_reg;
    assign out_q_v   = q_v_reg;
    assign out_tag   = tag_reg;

endmodule

### hdl/cube_map_face_select.sv
// Top level of the cube-map face select pipeline.
//
// Usage:
//   Input channel s_*: one direction vector per item (s_dir_x/y/z, signed).
//   Result channel m_*: face index (0 +X, 1 -X, 2 +Y, 3 -Y, 4 +Z, 5 -Z),
//   face coordinates u, v in unsigned Q1.15 (32768 = 1.0) and a degenerate
//   flag for the all-zero vector (then face 0, u = v = 0.5).
//   Both channels use valid/ready; an item moves when valid and ready are high.
//
// Throughput: one item per clock, sustained while m_ready stays high.
// Pipeline: 7 register stages: 1 major-axis select stage (loaded at the
//   accepting edge), 5 divider stages (3 quotient bits each, 15 bits total,
//   both coordinates in parallel lanes), 1 sign/offset output register.
//
// Reset (aresetn low, synchronous): all stage valid bits clear, pipeline empty.
// Backpressure: each stage holds its item while the next one is full and
//   stalled; bubbles still close up behind a stalled output. No item is
//   dropped or repeated. s_ready falls only once every stage is occupied.
module cube_map_face_select #(
    parameter int COMPONENT_BITS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [COMPONENT_BITS-1:0] s_dir_x,
    input  logic signed [COMPONENT_BITS-1:0] s_dir_y,
    input  logic signed [COMPONENT_BITS-1:0] s_dir_z,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [2:0]                       m_face_index,
    output logic [15:0]                      m_u_coord,
    output logic [15:0]                      m_v_coord,
    output logic                             m_degenerate
);
    import cmfs_pkg::*;

    localparam int N = COMPONENT_BITS;

    // Stage links: index 0 is the select stage output, k the k-th divider stage
    logic             vld_w   [DIV_STAGES+1];
    logic             rdy_w   [DIV_STAGES+1];
    logic [N-1:0]     major_w [DIV_STAGES+1];
    logic [N:0]       rem_u_w [DIV_STAGES+1];
    logic [N:0]       rem_v_w [DIV_STAGES+1];
    logic [QBITS-1:0] q_u_w   [DIV_STAGES+1];
    logic [QBITS-1:0] q_v_w   [DIV_STAGES+1];
    cmfs_tag_t        tag_w   [DIV_STAGES+1];

    // Output register
    logic                  m_valid_reg;
    logic [2:0]            face_reg, face_next;
    logic [COORD_BITS-1:0] u_reg, u_next;
    logic [COORD_BITS-1:0] v_reg, v_next;
    logic                  degen_reg;
    logic                  out_load;
    cmfs_tag_t             last_tag;
    logic [COORD_BITS-1:0] q_u_ext, q_v_ext;

    cmfs_select #(
        .N(N)
    ) u_select (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .dir_x     (s_dir_x),
        .dir_y     (s_dir_y),
        .dir_z     (s_dir_z),
        .out_valid (vld_w[0]),
        .out_ready (rdy_w[0]),
        .major     (major_w[0]),
        .rem_u     (rem_u_w[0]),
        .rem_v     (rem_v_w[0]),
        .tag       (tag_w[0])
    );

    // Quotient accumulators start empty; bits shift in from the bottom
    assign q_u_w[0] = '0;
    assign q_v_w[0] = '0;

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        cmfs_div_stage #(
            .N           (N),
            .STEPS       (DIV_STEPS_PER_STAGE),
            .FIRST_STAGE (k == 0)
        ) u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (vld_w[k]),
            .in_ready  (rdy_w[k]),
            .in_major  (major_w[k]),
            .in_rem_u  (rem_u_w[k]),
            .in_rem_v  (rem_v_w[k]),
            .in_q_u    (q_u_w[k]),
            .in_q_v    (q_v_w[k]),
            .in_tag    (tag_w[k]),
            .out_valid (vld_w[k+1]),
            .out_ready (rdy_w[k+1]),
            .out_major (major_w[k+1]),
            .out_rem_u (rem_u_w[k+1]),
            .out_rem_v (rem_v_w[k+1]),
            .out_q_u   (q_u_w[k+1]),
            .out_q_v   (q_v_w[k+1]),
            .out_tag   (tag_w[k+1])
        );
    end

    // Final stage: apply the numerator sign (truncation toward zero comes from
    // dividing magnitudes) and add the 0.5 offset.
    assign last_tag = tag_w[DIV_STAGES];
    assign q_u_ext  = {{(COORD_BITS-QBITS){1'b0}}, q_u_w[DIV_STAGES]};
    assign q_v_ext  = {{(COORD_BITS-QBITS){1'b0}}, q_v_w[DIV_STAGES]};

    always_comb begin
        if (last_tag.degenerate) begin
            face_next = FACE_POS_X;
            u_next    = HALF_Q15;
            v_next    = HALF_Q15;
        end else begin
            face_next = last_tag.face;
            u_next    = last_tag.neg_u ? (HALF_Q15 - q_u_ext) : (HALF_Q15 + q_u_ext);
            v_next    = last_tag.neg_v ? (HALF_Q15 - q_v_ext) : (HALF_Q15 + q_v_ext);
        end
    end

    assign rdy_w[DIV_STAGES] = !m_valid_reg || m_ready;
    assign out_load          = vld_w[DIV_STAGES] && rdy_w[DIV_STAGES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (rdy_w[DIV_STAGES]) begin
            m_valid_reg <= vld_w[DIV_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            face_reg  <= face_next;
            u_reg     <= u_next;
            v_reg     <= v_next;
            degen_reg <= last_tag.degenerate;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_face_index = face_reg;
    assign m_u_coord    = u_reg;
    assign m_v_coord    = v_reg;
    assign m_degenerate = degen_reg;

endmodule
